FILE: rtl/swc_pkg.sv
// shared types, widths and constants of the sliding window correlation block
`default_nettype none
package swc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int WINDOW_MAX  = 1024;
    localparam int ADDR_W      = $clog2(WINDOW_MAX);
    localparam int LEN_W       = 11;
    localparam int SUM1_W      = 35;
    localparam int SUM2_W      = 58;
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int OPD_W       = 70;
    localparam int MUL_W       = 2 * OPD_W;
    localparam int FRAC_W      = 30;
    localparam int SRCH_W      = MUL_W + 2 * FRAC_W;
    localparam int Q_W         = FRAC_W + 1;
    localparam int BIT_W       = $clog2(Q_W);
    localparam int CORR_W      = 32;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [LEN_W-1:0]   LEN_RESET = LEN_W'(30);
    localparam logic [LEN_W-1:0]   LEN_MAX   = LEN_W'(WINDOW_MAX);
    localparam logic [Q_W-1:0]     Q_ONE     = Q_W'(1) << FRAC_W;
    localparam logic [PADDR_W-1:2] REG_WINDOW_LENGTH = '0;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_x;
        logic signed [SAMPLE_BITS-1:0] sample_y;
        logic                          restart;
    } swc_in_t;

    typedef struct packed {
        logic signed [CORR_W-1:0] correlation;
        logic                     flat_window;
    } swc_out_t;

    typedef struct packed {
        logic        [LEN_W-1:0]  n;
        logic signed [SUM1_W-1:0] sum_x;
        logic signed [SUM1_W-1:0] sum_y;
        logic signed [SUM2_W-1:0] sum_xy;
        logic signed [SUM2_W-1:0] sum_xx;
        logic signed [SUM2_W-1:0] sum_yy;
    } swc_job_t;

    function automatic logic [OPD_W-1:0] abs_opd(input logic signed [OPD_W-1:0] v);
        logic [OPD_W-1:0] r;
        r = v[OPD_W-1] ? OPD_W'(-v) : OPD_W'(v);
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/swc_front.sv
// front end: window delay line memory and exact running sums
`default_nettype none
module swc_front (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                clear,
    input  wire        [swc_pkg::LEN_W-1:0]    n,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  swc_pkg::swc_in_t                   s_data,
    output logic                               job_valid,
    input  wire                                job_ready,
    output swc_pkg::swc_job_t                  job
);
    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MUL  = 2'd1;
    localparam logic [1:0] F_SUM  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    localparam int SB = swc_pkg::SAMPLE_BITS;
    localparam int AW = swc_pkg::ADDR_W;
    localparam int LW = swc_pkg::LEN_W;
    localparam int S1 = swc_pkg::SUM1_W;
    localparam int S2 = swc_pkg::SUM2_W;
    localparam int PW = swc_pkg::PROD_W;

    logic [1:0]    state_reg, state_next;
    logic [LW-1:0] fill_reg;
    logic [AW-1:0] slot_reg;
    logic          full_reg, emit_reg, clr_reg;

    logic signed [SB-1:0] x_reg, y_reg, ox_reg, oy_reg;
    logic [2*SB-1:0]      old_rd_reg;
    logic signed [PW-1:0] pxy_reg, pxx_reg, pyy_reg, poxy_reg, poxx_reg, poyy_reg;
    logic signed [S1-1:0] sum_x_reg, sum_y_reg;
    logic signed [S2-1:0] sum_xy_reg, sum_xx_reg, sum_yy_reg;

    logic          accept;
    logic [LW-1:0] fill_base, fill_upd, slot_inc;
    logic [AW-1:0] slot_base, slot_cur, slot_nxt;
    logic          old_full;
    logic signed [SB-1:0] ox, oy;
    logic signed [S1-1:0] bx, by;
    logic signed [S2-1:0] bxy, bxx, byy;

    assign s_ready   = (state_reg == F_IDLE);
    assign accept    = s_valid && s_ready;
    assign job_valid = (state_reg == F_PUSH);

    always_comb begin
        fill_base = s_data.restart ? '0 : fill_reg;
        slot_base = s_data.restart ? '0 : slot_reg;
        slot_cur  = ({1'b0, slot_base} >= n) ? '0 : slot_base;
        old_full  = (fill_base >= n);
        fill_upd  = old_full ? fill_base : fill_base + LW'(1);
        slot_inc  = {1'b0, slot_cur} + LW'(1);
        slot_nxt  = (slot_inc >= n) ? '0 : slot_inc[AW-1:0];
    end

    assign ox = $signed(old_rd_reg[2*SB-1:SB]);
    assign oy = $signed(old_rd_reg[SB-1:0]);

    always_comb begin
        bx  = clr_reg ? '0 : sum_x_reg;
        by  = clr_reg ? '0 : sum_y_reg;
        bxy = clr_reg ? '0 : sum_xy_reg;
        bxx = clr_reg ? '0 : sum_xx_reg;
        byy = clr_reg ? '0 : sum_yy_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (accept) state_next = F_MUL;
            end
            F_MUL:  state_next = F_SUM;
            F_SUM:  state_next = emit_reg ? F_PUSH : F_IDLE;
            F_PUSH: begin
                if (job_ready) state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    // window memory, read of the oldest pair before it is overwritten
    logic [2*SB-1:0] win_mem [swc_pkg::WINDOW_MAX];
    always_ff @(posedge aclk) begin
        if (accept) begin
            win_mem[slot_cur] <= {s_data.sample_x, s_data.sample_y};
            old_rd_reg        <= win_mem[slot_cur];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= F_IDLE;
            fill_reg   <= '0;
            slot_reg   <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xy_reg <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (clear) begin
                fill_reg   <= '0;
                slot_reg   <= '0;
                sum_x_reg  <= '0;
                sum_y_reg  <= '0;
                sum_xy_reg <= '0;
                sum_xx_reg <= '0;
                sum_yy_reg <= '0;
            end else if (accept) begin
                fill_reg <= fill_upd;
                slot_reg <= slot_nxt;
            end else if (state_reg == F_SUM) begin
                sum_x_reg  <= bx + S1'(x_reg) - S1'(ox_reg);
                sum_y_reg  <= by + S1'(y_reg) - S1'(oy_reg);
                sum_xy_reg <= bxy + S2'(pxy_reg) - S2'(poxy_reg);
                sum_xx_reg <= bxx + S2'(pxx_reg) - S2'(poxx_reg);
                sum_yy_reg <= byy + S2'(pyy_reg) - S2'(poyy_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x_reg    <= s_data.sample_x;
            y_reg    <= s_data.sample_y;
            clr_reg  <= s_data.restart;
            full_reg <= old_full;
            emit_reg <= (fill_upd >= n);
        end
        if (state_reg == F_MUL) begin
            pxy_reg  <= x_reg * y_reg;
            pxx_reg  <= x_reg * x_reg;
            pyy_reg  <= y_reg * y_reg;
            // signed products of the leaving pair, zero while filling
            if (full_reg) begin
                ox_reg   <= ox;
                oy_reg   <= oy;
                poxy_reg <= ox * oy;
                poxx_reg <= ox * ox;
                poyy_reg <= oy * oy;
            end else begin
                ox_reg   <= '0;
                oy_reg   <= '0;
                poxy_reg <= '0;
                poxx_reg <= '0;
                poyy_reg <= '0;
            end
        end
    end

    always_comb begin
        job.n      = n;
        job.sum_x  = sum_x_reg;
        job.sum_y  = sum_y_reg;
        job.sum_xy = sum_xy_reg;
        job.sum_xx = sum_xx_reg;
        job.sum_yy = sum_yy_reg;
    end

endmodule
`default_nettype wire

FILE: rtl/swc_fifo.sv
// short queue of window sum snapshots between front and back end
`default_nettype none
module swc_fifo (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 push,
    input  swc_pkg::swc_job_t   push_data,
    output logic                full,
    input  wire                 pop,
    output swc_pkg::swc_job_t   pop_data,
    output logic                not_empty
);
    localparam int AW = swc_pkg::FIFO_AW;

    swc_pkg::swc_job_t mem_reg [swc_pkg::FIFO_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          do_push, do_pop;

    assign full      = (count_reg == (AW+1)'(swc_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + AW'(1);
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + AW'(1);
            if (do_push && !do_pop)      count_reg <= count_reg + (AW+1)'(1);
            else if (do_pop && !do_push) count_reg <= count_reg - (AW+1)'(1);
        end
    end

endmodule
`default_nettype wire

FILE: rtl/swc_mul.sv
// shift and add multiplier, one multiplier bit per cycle, early stop
`default_nettype none
module swc_mul (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  start,
    input  wire        [swc_pkg::OPD_W-1:0]      opd_a,
    input  wire        [swc_pkg::OPD_W-1:0]      opd_b,
    input  wire                                  negate,
    output logic                                 done,
    output logic signed [swc_pkg::MUL_W-1:0]     product
);
    localparam int MW = swc_pkg::MUL_W;

    logic                        run_reg, done_reg, neg_reg;
    logic [MW-1:0]               mcand_reg, acc_reg;
    logic [swc_pkg::OPD_W-1:0]   mplier_reg;
    logic signed [MW-1:0]        product_reg;
    logic                        finish;

    assign finish  = run_reg && (mplier_reg == '0);
    assign done    = done_reg;
    assign product = product_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= finish;
            if (start)       run_reg <= 1'b1;
            else if (finish) run_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg  <= MW'(opd_a);
            mplier_reg <= opd_b;
            acc_reg    <= '0;
            neg_reg    <= negate;
        end else if (finish) begin
            product_reg <= neg_reg ? $signed(-acc_reg) : $signed(acc_reg);
        end else if (run_reg) begin
            if (mplier_reg[0]) acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/swc_back.sv
// back end: numerator, variances and bitwise search for the coefficient
`default_nettype none
module swc_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  job_valid,
    output logic                 job_pop,
    input  swc_pkg::swc_job_t    job,
    output logic                 m_valid,
    input  wire                  m_ready,
    output swc_pkg::swc_out_t    m_data
);
    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_LOAD  = 4'd1;
    localparam logic [3:0] B_WAIT  = 4'd2;
    localparam logic [3:0] B_CHECK = 4'd3;
    localparam logic [3:0] B_S0    = 4'd4;
    localparam logic [3:0] B_S1    = 4'd5;
    localparam logic [3:0] B_S2    = 4'd6;
    localparam logic [3:0] B_FIN   = 4'd7;
    localparam logic [3:0] B_OUT   = 4'd8;

    localparam logic [2:0] STEP_NSXY  = 3'd0;
    localparam logic [2:0] STEP_SXSY  = 3'd1;
    localparam logic [2:0] STEP_NSXX  = 3'd2;
    localparam logic [2:0] STEP_SXSX  = 3'd3;
    localparam logic [2:0] STEP_NSYY  = 3'd4;
    localparam logic [2:0] STEP_SYSY  = 3'd5;
    localparam logic [2:0] STEP_VXVY  = 3'd6;
    localparam logic [2:0] STEP_NUMSQ = 3'd7;

    localparam int OW = swc_pkg::OPD_W;
    localparam int MW = swc_pkg::MUL_W;
    localparam int SW = swc_pkg::SRCH_W;
    localparam int QW = swc_pkg::Q_W;
    localparam int CW = swc_pkg::CORR_W;
    localparam int FW = swc_pkg::FRAC_W;

    logic [3:0]   state_reg;
    logic [2:0]   step_reg;
    swc_pkg::swc_job_t job_reg;

    logic signed [MW-1:0] hold_reg;
    logic signed [OW-1:0] num_reg, vx_reg, vy_reg;
    logic [MW-1:0]        d_reg;
    logic [SW-1:0]        p_reg, a_reg, b_reg, t_reg, s1_reg, cand_reg;
    logic                 take_reg;
    logic [swc_pkg::BIT_W-1:0] bit_reg;
    logic [QW-1:0]        q_reg;

    swc_pkg::swc_out_t res_reg, out_reg;
    logic              out_valid_reg;

    logic signed [OW-1:0] sel_a, sel_b, n_opd;
    logic                 mul_start, mul_done;
    logic signed [MW-1:0] mul_product, diff;
    logic [QW-1:0]        q_sat;
    logic [CW-1:0]        q_ext;
    logic                 load_out;

    assign n_opd = $signed(OW'(job_reg.n));

    // operand pairs for each product step; the window length goes second
    // so the serial multiplier stops after few bits
    always_comb begin
        case (step_reg)
            STEP_NSXY:  begin sel_a = OW'(job_reg.sum_xy); sel_b = n_opd;           end
            STEP_SXSY:  begin sel_a = OW'(job_reg.sum_x);  sel_b = OW'(job_reg.sum_y); end
            STEP_NSXX:  begin sel_a = OW'(job_reg.sum_xx); sel_b = n_opd;           end
            STEP_SXSX:  begin sel_a = OW'(job_reg.sum_x);  sel_b = OW'(job_reg.sum_x); end
            STEP_NSYY:  begin sel_a = OW'(job_reg.sum_yy); sel_b = n_opd;           end
            STEP_SYSY:  begin sel_a = OW'(job_reg.sum_y);  sel_b = OW'(job_reg.sum_y); end
            STEP_VXVY:  begin sel_a = vx_reg;              sel_b = vy_reg;          end
            STEP_NUMSQ: begin sel_a = num_reg;             sel_b = num_reg;         end
            default:    begin sel_a = '0;                  sel_b = '0;              end
        endcase
    end

    assign mul_start = (state_reg == B_LOAD);

    swc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .opd_a   (swc_pkg::abs_opd(sel_a)),
        .opd_b   (swc_pkg::abs_opd(sel_b)),
        .negate  (sel_a[OW-1] ^ sel_b[OW-1]),
        .done    (mul_done),
        .product (mul_product)
    );

    assign diff    = hold_reg - mul_product;
    assign q_sat   = (q_reg > swc_pkg::Q_ONE) ? swc_pkg::Q_ONE : q_reg;
    assign q_ext   = CW'(q_sat);
    assign job_pop = (state_reg == B_IDLE) && job_valid;
    assign load_out = (state_reg == B_OUT) && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            step_reg      <= STEP_NSXY;
            out_valid_reg <= 1'b0;
        end else begin
            if (load_out)     out_valid_reg <= 1'b1;
            else if (m_ready) out_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE: begin
                    if (job_valid) begin
                        step_reg  <= STEP_NSXY;
                        state_reg <= B_LOAD;
                    end
                end
                B_LOAD: state_reg <= B_WAIT;
                B_WAIT: begin
                    if (mul_done) begin
                        step_reg <= step_reg + 3'd1;
                        if (step_reg == STEP_SYSY)       state_reg <= B_CHECK;
                        else if (step_reg == STEP_NUMSQ) state_reg <= B_S0;
                        else                             state_reg <= B_LOAD;
                    end
                end
                B_CHECK: begin
                    if (vx_reg[OW-1] || vx_reg == '0 || vy_reg[OW-1] || vy_reg == '0)
                        state_reg <= B_OUT;
                    else
                        state_reg <= B_LOAD;
                end
                B_S0: state_reg <= B_S1;
                B_S1: state_reg <= B_S2;
                B_S2: state_reg <= (bit_reg == '0) ? B_FIN : B_S0;
                B_FIN: state_reg <= B_OUT;
                B_OUT: begin
                    if (load_out) state_reg <= B_IDLE;
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (job_pop) job_reg <= job;
        if (state_reg == B_WAIT && mul_done) begin
            case (step_reg)
                STEP_NSXY, STEP_NSXX, STEP_NSYY: hold_reg <= mul_product;
                STEP_SXSY:  num_reg <= $signed(diff[OW-1:0]);
                STEP_SXSX:  vx_reg  <= $signed(diff[OW-1:0]);
                STEP_SYSY:  vy_reg  <= $signed(diff[OW-1:0]);
                STEP_VXVY:  d_reg   <= mul_product;
                STEP_NUMSQ: begin
                    // search invariant: a = q*d << (bit+1), b = d << 2*bit
                    t_reg   <= {mul_product, {(2*FW){1'b0}}};
                    b_reg   <= {d_reg, {(2*FW){1'b0}}};
                    p_reg   <= '0;
                    a_reg   <= '0;
                    q_reg   <= '0;
                    bit_reg <= swc_pkg::BIT_W'(FW);
                end
                default: hold_reg <= hold_reg;
            endcase
        end
        if (state_reg == B_CHECK) begin
            res_reg.correlation <= '0;
            res_reg.flat_window <= 1'b1;
        end
        if (state_reg == B_S0) s1_reg <= p_reg + a_reg;
        if (state_reg == B_S1) begin
            cand_reg <= s1_reg + b_reg;
            take_reg <= (s1_reg + b_reg) <= t_reg;
        end
        if (state_reg == B_S2) begin
            if (take_reg) begin
                p_reg <= cand_reg;
                q_reg <= q_reg | (QW'(1) << bit_reg);
            end
            a_reg   <= (a_reg >> 1) + (take_reg ? b_reg : '0);
            b_reg   <= b_reg >> 2;
            bit_reg <= bit_reg - swc_pkg::BIT_W'(1);
        end
        if (state_reg == B_FIN) begin
            res_reg.correlation <= num_reg[OW-1] ? $signed(-q_ext) : $signed(q_ext);
            res_reg.flat_window <= 1'b0;
        end
        if (load_out) out_reg <= res_reg;
    end

endmodule
`default_nettype wire

FILE: rtl/sliding_window_correlation.sv
// top level of the sliding window correlation block
// Rolling Pearson correlation of paired 24-bit signed samples over the last
// N pairs (N = window_length, 0 acts as 1, above 1024 acts as 1024). Each
// accepted pair updates the window memory and the exact running sums in the
// states F_IDLE, F_MUL and F_SUM, with F_PUSH to hand a sum snapshot to the
// queue when a result is due; once the window holds N pairs, every pair
// yields one result, r = (N*Sxy - Sx*Sy) / sqrt(vx*vy) in Q1.30, truncated
// toward zero and saturated to +-1.0, or 0 with flat_window set when either
// variance term is not positive. Results come from a back end built around
// one shift-and-add multiplier and a 31-step bitwise search; it is quicker
// for small sums, and its time per result sets the sustained rate while the
// window is full. A 4-entry queue of sum snapshots between the two ends lets
// the front take pairs until it fills, while the back end works and while
// a finished result waits in the output register. restart on a pair clears
// the window before that pair is taken in; a write of window_length (byte
// address 0) also clears it and must only be done while the block is idle.
`default_nettype none
module sliding_window_correlation (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    // input transaction
    input  wire                                  s_valid,
    output logic                                 s_ready,
    input  swc_pkg::swc_in_t                     s_data,
    // result transaction
    output logic                                 m_valid,
    input  wire                                  m_ready,
    output swc_pkg::swc_out_t                    m_data,
    // configuration
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire        [swc_pkg::PADDR_W-1:0]    paddr,
    input  wire        [swc_pkg::PDATA_W-1:0]    pwdata,
    output logic       [swc_pkg::PDATA_W-1:0]    prdata,
    output logic                                 pready
);
    localparam int LW = swc_pkg::LEN_W;

    logic [LW-1:0]     window_length_reg;
    logic [LW-1:0]     n_eff;
    logic              reg_hit, cfg_write;
    logic              job_valid, fifo_full, fifo_not_empty, job_pop;
    swc_pkg::swc_job_t front_job, back_job;

    // register decode: one register, window_length
    assign pready    = 1'b1;
    assign reg_hit   = (paddr[swc_pkg::PADDR_W-1:2] == swc_pkg::REG_WINDOW_LENGTH);
    assign cfg_write = psel && penable && pwrite && pready && reg_hit;
    assign prdata    = reg_hit ? swc_pkg::PDATA_W'(window_length_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= swc_pkg::LEN_RESET;
        end else if (cfg_write) begin
            window_length_reg <= pwdata[LW-1:0];
        end
    end

    // effective window length, clamped into 1..WINDOW_MAX
    always_comb begin
        if (window_length_reg == '0)                 n_eff = LW'(1);
        else if (window_length_reg > swc_pkg::LEN_MAX) n_eff = swc_pkg::LEN_MAX;
        else                                         n_eff = window_length_reg;
    end

    // front: delay lines and running sums, one snapshot per pair once the window is full
    swc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (cfg_write),
        .n         (n_eff),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (job_valid),
        .job_ready (!fifo_full),
        .job       (front_job)
    );

    // snapshot queue decouples the two ends
    swc_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_valid),
        .push_data (front_job),
        .full      (fifo_full),
        .pop       (job_pop),
        .pop_data  (back_job),
        .not_empty (fifo_not_empty)
    );

    // back: products, variance check and coefficient search
    swc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (fifo_not_empty),
        .job_pop   (job_pop),
        .job       (back_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

FILE: rtl/swc_checker.sv
// port level checks of the sliding window correlation block and their bind
`default_nettype none
module swc_checker (
    input wire                                  aclk,
    input wire                                  aresetn,
    input wire                                  m_valid,
    input wire                                  m_ready,
    input swc_pkg::swc_out_t                    m_data,
    input wire                                  psel,
    input wire                                  penable,
    input wire                                  pwrite,
    input wire        [swc_pkg::PADDR_W-1:0]    paddr,
    input wire        [swc_pkg::PDATA_W-1:0]    pwdata,
    input wire        [swc_pkg::PDATA_W-1:0]    prdata
);
    localparam logic signed [swc_pkg::CORR_W-1:0] ONE_POS =
        swc_pkg::CORR_W'(swc_pkg::Q_ONE);
    localparam logic signed [swc_pkg::CORR_W-1:0] ONE_NEG = -ONE_POS;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_flat_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.flat_window |-> m_data.correlation == '0)
        else $error("flat window with nonzero correlation");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.correlation <= ONE_POS && m_data.correlation >= ONE_NEG)
        else $error("correlation outside plus or minus one");

    a_write_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && paddr == '0 && pwdata[10:0] == 11'd5
        |=> prdata == swc_pkg::PDATA_W'(5) || paddr != '0)
        else $error("window length write not read back");

endmodule

bind sliding_window_correlation swc_checker u_swc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata)
);
`default_nettype wire

FILE: bench/tb_sliding_window_correlation.sv
// self-checking testbench for the sliding window correlation block
`timescale 1ns / 1ps
`default_nettype none
module tb_sliding_window_correlation;

    localparam int STALL_LIMIT = 4000;   // cycles without any handshake
    localparam int DRAIN_WAIT  = 500;
    localparam int RANDOM_ITEMS = 1200;

    localparam int SB  = swc_pkg::SAMPLE_BITS;
    localparam int LW  = swc_pkg::LEN_W;
    localparam int PAW = swc_pkg::PADDR_W;
    localparam int PDW = swc_pkg::PDATA_W;
    localparam int WMAX = swc_pkg::WINDOW_MAX;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    swc_pkg::swc_in_t     s_data;
    logic                 m_valid;
    logic                 m_ready;
    swc_pkg::swc_out_t    m_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PAW-1:0]       paddr;
    logic [PDW-1:0]       pwdata;
    logic [PDW-1:0]       prdata;
    logic                 pready;

    sliding_window_correlation u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock, 4 ns period
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // correlation predictor state: window copy, running sums, length
    // ---------------------------------------------------------------
    logic signed [SB-1:0] win_x [WMAX];
    logic signed [SB-1:0] win_y [WMAX];
    longint        acc_x, acc_y, acc_xy, acc_xx, acc_yy;
    int unsigned   pairs_held;
    int unsigned   next_slot;
    logic [LW-1:0] length_reg;

    swc_pkg::swc_out_t expected_results [$];
    int       mismatches;
    bit       no_idle;        // phases with back-to-back traffic on both sides
    int       quiet_cycles;

    function automatic void clear_sums();
        acc_x = 0; acc_y = 0; acc_xy = 0; acc_xx = 0; acc_yy = 0;
        pairs_held = 0;
        next_slot  = 0;
    endfunction

    function automatic int unsigned active_length();
        if (length_reg == 0) return 1;
        if (length_reg > LW'(WMAX)) return WMAX;
        return int'(length_reg);
    endfunction

    // updates the window with one pair; returns 1 and the result once the window is full
    function automatic bit correlate_pair(input swc_pkg::swc_in_t pair,
                                          output swc_pkg::swc_out_t res);
        longint                 xs, ys, ox, oy;
        int unsigned            n, slot;
        logic signed [127:0]    nn, num, vx, vy;
        logic [255:0]           num_mag, denom, target, cand, prod;
        logic [31:0]            q;
        xs = longint'(pair.sample_x);
        ys = longint'(pair.sample_y);
        n  = active_length();
        res = '0;
        if (pair.restart) clear_sums();
        if (next_slot >= n) next_slot = 0;
        slot = next_slot;
        if (pairs_held >= n) begin
            ox = longint'(win_x[slot]);
            oy = longint'(win_y[slot]);
            acc_x -= ox; acc_y -= oy;
            acc_xy -= ox * oy; acc_xx -= ox * ox; acc_yy -= oy * oy;
        end else begin
            pairs_held++;
        end
        win_x[slot] = pair.sample_x;
        win_y[slot] = pair.sample_y;
        acc_x += xs; acc_y += ys;
        acc_xy += xs * ys; acc_xx += xs * xs; acc_yy += ys * ys;
        next_slot = (slot + 1 >= n) ? 0 : slot + 1;
        if (pairs_held < n) return 1'b0;

        nn  = 128'(n);
        num = nn * 128'(acc_xy) - 128'(acc_x) * 128'(acc_y);
        vx  = nn * 128'(acc_xx) - 128'(acc_x) * 128'(acc_x);
        vy  = nn * 128'(acc_yy) - 128'(acc_y) * 128'(acc_y);
        if (vx <= 0 || vy <= 0) begin
            res.correlation = '0;
            res.flat_window = 1'b1;
            return 1'b1;
        end
        num_mag = (num < 0) ? 256'(-num) : 256'(num);
        denom   = 256'(vx) * 256'(vy);
        target  = (num_mag * num_mag) << 60;
        // bitwise search for floor(|num| * 2^30 / sqrt(vx*vy))
        q = 0;
        for (int b = swc_pkg::FRAC_W; b >= 0; b--) begin
            cand = 256'(q | (32'd1 << b));
            prod = cand * cand * denom;
            if (prod <= target) q = q | (32'd1 << b);
        end
        if (q > 32'(swc_pkg::Q_ONE)) q = 32'(swc_pkg::Q_ONE);
        if (num < 0) q = -q;
        res.correlation = q;
        res.flat_window = 1'b0;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // result checker: every result transaction against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        swc_pkg::swc_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: corr=%0d flat=%0b",
                             m_data.correlation, m_data.flat_window);
            end else begin
                want = expected_results.pop_front();
                if (m_data.correlation !== want.correlation ||
                    m_data.flat_window !== want.flat_window) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: corr exp=%0d got=%0d, flat exp=%0b got=%0b",
                                 want.correlation, m_data.correlation,
                                 want.flat_window, m_data.flat_window);
                end
            end
        end
    end

    // watchdog: counts cycles in which no transaction of any kind completes
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("sliding_window_correlation regression: fail");
            $finish;
        end
    end

    // receiver side: random back-pressure before each result, none in no_idle phases
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // ---------------------------------------------------------------
    // register access
    // ---------------------------------------------------------------
    task automatic write_length(input logic [PDW-1:0] value);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {swc_pkg::REG_WINDOW_LENGTH, 2'b00};
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        length_reg = value[LW-1:0];
        clear_sums();
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        // read it back
        @(negedge aclk);
        psel <= 1'b1;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata[LW-1:0] !== length_reg) begin
            mismatches++;
            if (mismatches <= 10)
                $display("window_length readback: exp=%0d got=%0d",
                         length_reg, prdata[LW-1:0]);
        end
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0;
    endtask

    // holds off until all results are in and the front end has gone quiet
    task automatic wait_idle();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // sender: one pair transaction, with an optional typed expectation
    // ---------------------------------------------------------------
    task automatic send_pair(input swc_pkg::swc_in_t pair, input bit typed,
                             input swc_pkg::swc_out_t typed_res);
        int                gap;
        swc_pkg::swc_out_t res;
        @(negedge aclk);
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= pair;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        if (correlate_pair(pair, res))
            expected_results.push_back(typed ? typed_res : res);
    endtask

    task automatic end_burst();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------
    // directed table
    // ---------------------------------------------------------------
    typedef enum logic { ROW_LENGTH, ROW_PAIR } row_kind_t;
    typedef struct {
        row_kind_t            kind;
        int                   x;      // also the length value for ROW_LENGTH
        int                   y;
        bit                   restart;
        bit                   typed;
        int                   corr;
        bit                   flat;
    } dir_row_t;

    localparam int XMAX = 8388607;
    localparam int XMIN = -8388608;
    localparam int QONE = 1073741824;

    dir_row_t dir_rows [] = '{
        '{ROW_LENGTH, 1,    0,    0, 0, 0, 0},
        '{ROW_PAIR,   XMAX, XMIN, 0, 1, 0, 1},    // window of one is always flat
        '{ROW_PAIR,   XMIN, XMAX, 1, 1, 0, 1},
        '{ROW_LENGTH, 0,    0,    0, 0, 0, 0},    // zero acts as one
        '{ROW_PAIR,   0,    0,    0, 1, 0, 1},
        '{ROW_LENGTH, 2,    0,    0, 0, 0, 0},
        '{ROW_PAIR,   XMAX, XMAX, 0, 0, 0, 0},
        '{ROW_PAIR,   XMIN, XMIN, 0, 1, QONE, 0}, // two points: exactly +1
        '{ROW_PAIR,   XMIN, XMAX, 1, 0, 0, 0},
        '{ROW_PAIR,   XMAX, XMIN, 0, 1, -QONE, 0},// exactly -1
        '{ROW_PAIR,   5,    7,    1, 0, 0, 0},
        '{ROW_PAIR,   5,    -3,   0, 1, 0, 1},    // constant x
        '{ROW_PAIR,   -1,   -1,   1, 0, 0, 0},
        '{ROW_PAIR,   -1,   -1,   0, 1, 0, 1},    // both constant
        '{ROW_LENGTH, 3,    0,    0, 0, 0, 0},
        '{ROW_PAIR,   1,    XMAX, 0, 0, 0, 0},
        '{ROW_PAIR,   2,    XMIN, 0, 0, 0, 0},
        '{ROW_PAIR,   3,    0,    0, 0, 0, 0},
        '{ROW_PAIR,   XMAX, 11,   0, 0, 0, 0},
        '{ROW_PAIR,   XMIN, -11,  0, 0, 0, 0},
        '{ROW_PAIR,   0,    1,    1, 0, 0, 0},
        '{ROW_PAIR,   0,    2,    0, 0, 0, 0},
        '{ROW_PAIR,   7,    -5,   0, 0, 0, 0}
    };

    // random sample by style: full range, tiny, extremes
    function automatic logic signed [SB-1:0] draw_sample(input int style);
        case (style)
            0: draw_sample = SB'($urandom);
            1: draw_sample = SB'(int'($urandom_range(0, 15)) - 8);
            default: begin
                case ($urandom_range(0, 3))
                    0: draw_sample = SB'(XMAX);
                    1: draw_sample = SB'(XMIN);
                    2: draw_sample = '0;
                    default: draw_sample = '1;
                endcase
            end
        endcase
    endfunction

    initial begin
        swc_pkg::swc_in_t  pair;
        swc_pkg::swc_out_t typed_res;
        int          sent, items, style, n;
        int          lengths [$];
        logic signed [SB-1:0] fixed_x;
        aresetn = 1'b0;
        s_valid = 1'b0; s_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatches = 0; quiet_cycles = 0; no_idle = 1'b0;
        length_reg = swc_pkg::LEN_RESET;
        clear_sums();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset length of 30: fill the window and take a few results
        for (int i = 0; i < 33; i++) begin
            pair.sample_x = draw_sample(0);
            pair.sample_y = draw_sample(0);
            pair.restart  = 1'b0;
            send_pair(pair, 1'b0, '0);
        end
        end_burst();
        wait_idle();

        // directed rows
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_LENGTH) begin
                end_burst();
                wait_idle();
                write_length(PDW'(dir_rows[i].x));
            end else begin
                pair.sample_x = SB'(dir_rows[i].x);
                pair.sample_y = SB'(dir_rows[i].y);
                pair.restart  = dir_rows[i].restart;
                typed_res.correlation = dir_rows[i].corr;
                typed_res.flat_window = dir_rows[i].flat;
                send_pair(pair, dir_rows[i].typed, typed_res);
            end
        end
        end_burst();

        // random phases; the oversized length (acts as 1024) runs once
        lengths = '{2047, 1, 2, 3, 4, 7, 16, 30, 0};
        sent = 0;
        while (sent < RANDOM_ITEMS || lengths.size() != 0) begin
            wait_idle();
            if (lengths.size() != 0) begin
                n = lengths.pop_front();
            end else begin
                n = $urandom_range(1, 40);
            end
            write_length(PDW'(n));
            no_idle = ($urandom_range(0, 3) == 0);
            fixed_x = draw_sample(0);
            n = active_length();
            items = (n > 64) ? n + 6 : n + $urandom_range(10, 40);
            for (int i = 0; i < items; i++) begin
                style = $urandom_range(0, 9);
                pair.sample_x = draw_sample(style < 6 ? 0 : (style < 8 ? 1 : 2));
                case ($urandom_range(0, 7))
                    0, 1: pair.sample_y = pair.sample_x + draw_sample(1);
                    2:    pair.sample_y = -pair.sample_x + draw_sample(1);
                    default: pair.sample_y = draw_sample(style < 6 ? 0 : (style < 8 ? 1 : 2));
                endcase
                if (style == 9 && n < 64) pair.sample_x = fixed_x;
                pair.restart = (n < 64) && ($urandom_range(0, 49) == 0);
                send_pair(pair, 1'b0, '0);
                sent++;
                if (i == items / 2 && $urandom_range(0, 3) == 0) begin
                    end_burst();
                    while (expected_results.size() != 0) @(posedge aclk);
                end
            end
            end_burst();
            no_idle = 1'b0;
        end

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("sliding_window_correlation regression: pass");
        else
            $display("sliding_window_correlation regression: fail");
        $finish;
    end

endmodule
`default_nettype wire
